FILE: rtl/pdq_pkg.sv
// Package for the priority dispatch queue.
// Holds command and status codes, field widths, the FSM state type and the
// control struct shared by the controller and the datapath. No dependencies.
package pdq_pkg;

	// Beat field widths (fixed by the stream format)
	localparam int CMD_W  = 2;
	localparam int ID_W   = 8;
	localparam int PRIO_W = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	// Packed beat widths, rounded up to whole bytes
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NO_TAKE   = 2'd3;

	// Controller states
	typedef enum logic {
		S_IDLE,
		S_APPLY
	} pdq_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;  // latch command and per-slot compare bits
		logic apply;    // commit slot update and load result register
	} pdq_ctl_t;

endpackage

FILE: rtl/pdq_ctrl.sv
// Controller for the priority dispatch queue.
// Sequences capture and apply steps and owns both stream handshakes.
// Depends on pdq_pkg.
module pdq_ctrl
	import pdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	output logic     s_axis_tready,
	output logic     m_axis_tvalid,
	input  logic     m_axis_tready,
	output pdq_ctl_t ctl
);

	pdq_state_t state_q, state_nxt;
	logic       out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt     = state_q;
		s_axis_tready = 1'b0;
		ctl           = '0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					ctl.capture = 1'b1;
					state_nxt   = S_APPLY;
				end
			end
			S_APPLY: begin
				// commit only when the result register is free or draining
				if (!out_valid_q || m_axis_tready) begin
					ctl.apply = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.apply) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;

endmodule

FILE: rtl/pdq_datapath.sv
// Datapath for the priority dispatch queue: sorted slot array with two
// comparators per slot, prefix-OR for remove matching, count and result regs.
// Depends on pdq_pkg.
module pdq_datapath
	import pdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pdq_ctl_t           ctl,
	input  logic [CMD_W-1:0]   command,
	input  logic [ID_W-1:0]    job_id,
	input  logic [PRIO_W-1:0]  job_priority,
	input  logic [PRIO_W-1:0]  take_threshold,
	output logic [ID_W-1:0]    taken_id,
	output logic [STAT_W-1:0]  status,
	output logic [OCC_W-1:0]   occupancy
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LVLS  = $clog2(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	// Slot storage, slot 0 is the front
	logic [PRIO_W-1:0]  slot_prio_q [QUEUE_DEPTH];
	logic [ID_BITS-1:0] slot_id_q   [QUEUE_DEPTH];
	logic [CNT_W-1:0]   count_q;

	// Captured command and compare results
	logic [CMD_W-1:0]       cmd_q;
	logic [ID_BITS-1:0]     id_q;
	logic [PRIO_W-1:0]      prio_q;
	logic [QUEUE_DEPTH-1:0] le_q;     // slot prio <= new prio, or slot empty
	logic [QUEUE_DEPTH-1:0] match_q;  // occupied slot with matching id
	logic                   full_q;
	logic                   front_ok_q;

	logic [ID_BITS-1:0]     id_in;
	logic [QUEUE_DEPTH-1:0] le_c;
	logic [QUEUE_DEPTH-1:0] match_c;
	logic [QUEUE_DEPTH-1:0] pfx [LVLS+1];
	logic [QUEUE_DEPTH-1:0] hit;
	logic                   found;

	logic [PRIO_W-1:0]  nxt_prio [QUEUE_DEPTH];
	logic [ID_BITS-1:0] nxt_id   [QUEUE_DEPTH];
	logic [CNT_W-1:0]   count_nxt;
	logic [ID_W-1:0]    taken_nxt;
	logic [STAT_W-1:0]  status_nxt;

	logic [ID_W-1:0]    taken_q;
	logic [STAT_W-1:0]  status_q;
	logic [OCC_W-1:0]   occ_q;

	assign id_in = ID_BITS'(job_id);

	// Per-slot cells: compare at capture, next value at apply
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic               occupied;
		logic               le_prev;
		logic [PRIO_W-1:0]  up_prio, dn_prio;
		logic [ID_BITS-1:0] up_id, dn_id;

		assign occupied   = CNT_W'(k) < count_q;
		assign le_c[k]    = !occupied || (slot_prio_q[k] <= job_priority);
		assign match_c[k] = occupied && (slot_id_q[k] == id_in);

		if (k < QUEUE_DEPTH - 1) begin : g_up
			assign up_prio = slot_prio_q[k+1];
			assign up_id   = slot_id_q[k+1];
		end else begin : g_last
			assign up_prio = slot_prio_q[k];
			assign up_id   = slot_id_q[k];
		end

		if (k > 0) begin : g_dn
			assign dn_prio = slot_prio_q[k-1];
			assign dn_id   = slot_id_q[k-1];
			assign le_prev = le_q[k-1];
		end else begin : g_first
			assign dn_prio = slot_prio_q[k];
			assign dn_id   = slot_id_q[k];
			assign le_prev = 1'b0;
		end

		always_comb begin
			nxt_prio[k] = slot_prio_q[k];
			nxt_id[k]   = slot_id_q[k];
			case (cmd_q)
				CMD_INSERT: begin
					if (!full_q) begin
						if (le_prev) begin
							nxt_prio[k] = dn_prio;
							nxt_id[k]   = dn_id;
						end else if (le_q[k]) begin
							nxt_prio[k] = prio_q;
							nxt_id[k]   = id_q;
						end
					end
				end
				CMD_REMOVE: begin
					if (hit[k]) begin
						nxt_prio[k] = up_prio;
						nxt_id[k]   = up_id;
					end
				end
				CMD_TAKE: begin
					if (front_ok_q) begin
						nxt_prio[k] = up_prio;
						nxt_id[k]   = up_id;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Prefix OR of match bits: hit[k] set at and after the front-most match
	always_comb begin
		pfx[0] = match_q;
		for (int l = 0; l < LVLS; l++) begin
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				if (k >= (1 << l)) begin
					pfx[l+1][k] = pfx[l][k] | pfx[l][k-(1<<l)];
				end else begin
					pfx[l+1][k] = pfx[l][k];
				end
			end
		end
	end

	assign hit   = pfx[LVLS];
	assign found = hit[QUEUE_DEPTH-1];

	// Capture stage
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q      <= command;
			id_q       <= id_in;
			prio_q     <= job_priority;
			le_q       <= le_c;
			match_q    <= match_c;
			full_q     <= (count_q == FULL_CNT);
			front_ok_q <= (count_q != '0) && (slot_prio_q[0] >= take_threshold);
		end
	end

	// Result and new count
	always_comb begin
		count_nxt  = count_q;
		taken_nxt  = '0;
		status_nxt = STAT_DONE;
		case (cmd_q)
			CMD_INSERT: begin
				if (full_q) begin
					status_nxt = STAT_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					count_nxt = count_q - 1'b1;
				end else begin
					status_nxt = STAT_NOT_FOUND;
				end
			end
			CMD_TAKE: begin
				if (front_ok_q) begin
					count_nxt = count_q - 1'b1;
					taken_nxt = ID_W'(slot_id_q[0]);
				end else begin
					status_nxt = STAT_NO_TAKE;
				end
			end
			default: begin
			end
		endcase
	end

	// Slot array update
	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				slot_prio_q[k] <= nxt_prio[k];
				slot_id_q[k]   <= nxt_id[k];
			end
		end
	end

	// Job count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.apply) begin
			count_q <= count_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			taken_q  <= taken_nxt;
			status_q <= status_nxt;
			occ_q    <= OCC_W'(count_nxt);
		end
	end

	assign taken_id  = taken_q;
	assign status    = status_q;
	assign occupancy = occ_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("job count above queue depth");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |-> !ctl.apply)
		else $error("capture and apply in the same cycle");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.apply && cmd_q == CMD_INSERT && !full_q) |=>
		count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the queue by one");

	a_missing_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.apply && cmd_q == CMD_REMOVE && !found) |=> $stable(count_q))
		else $error("remove of absent id changed the count");

endmodule

FILE: rtl/priority_dispatch_queue.sv
// Priority dispatch queue, top level.
// Joins the controller and the slot-array datapath. Depends on pdq_pkg,
// pdq_ctrl and pdq_datapath.
//
//  channel   dir  width  contents (low bit first)
//  s_axis    in   80     command[1:0] job_id[9:2] job_priority[41:10]
//                        take_threshold[73:42], zero fill
//  m_axis    out  16     taken_id[7:0] status[9:8] occupancy[14:10], zero fill
//
// Per command, the accept edge registers the compare results of each slot and
// the apply edge then shifts the slot array and loads the result register.
// A new beat is accepted only in the idle state, which follows each apply step.
// A stalled result holds the controller in its apply step until taken.
// Reset empties the queue at once; no clearing pass is needed.
module priority_dispatch_queue
	import pdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// command, job_id, job_priority, take_threshold
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// taken_id, status, occupancy
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	pdq_ctl_t          ctl;
	logic [ID_W-1:0]   taken_id;
	logic [STAT_W-1:0] status;
	logic [OCC_W-1:0]  occupancy;

	pdq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.ctl           (ctl)
	);

	pdq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.command        (s_axis_tdata[1:0]),
		.job_id         (s_axis_tdata[9:2]),
		.job_priority   (s_axis_tdata[41:10]),
		.take_threshold (s_axis_tdata[73:42]),
		.taken_id       (taken_id),
		.status         (status),
		.occupancy      (occupancy)
	);

	// Output beat packing
	assign m_axis_tdata = {1'b0, occupancy, status, taken_id};

endmodule
